// File: rtl/core/tbp_pkg.sv
// Shared types, constants and helpers for the tournament branch predictor.
package tbp_pkg;

    typedef logic [1:0] t_ctr2;

    // Reset contents of the three counter tables.
    localparam t_ctr2 BIM_RESET = 2'd3;
    localparam t_ctr2 GSH_RESET = 2'd3;
    localparam t_ctr2 CHS_RESET = 2'd0;

    // A direction counter predicts taken at or above this value.
    localparam t_ctr2 TAKEN_THRESH = 2'd2;
    // A chooser value at or below this selects gshare.
    localparam t_ctr2 CHS_GSHARE_MAX = 2'd1;
    localparam t_ctr2 CTR_MAX = 2'd3;
    localparam t_ctr2 CTR_MIN = 2'd0;

    localparam int PC_W = 32;
    localparam int TOTAL_W = 32;

    // Slave tdata layout.
    localparam int S_PC_LSB = 0;
    localparam int S_TAKEN_BIT = PC_W;
    localparam int S_TDATA_W = 40;

    // Master tdata layout.
    localparam int M_PRED_BIT = 0;
    localparam int M_USEG_BIT = 1;
    localparam int M_OK_BIT = 2;
    localparam int M_CORRECT_LSB = 3;
    localparam int M_BRANCH_LSB = M_CORRECT_LSB + TOTAL_W;
    localparam int M_USED_W = M_BRANCH_LSB + TOTAL_W;
    localparam int M_TDATA_W = 72;

    // Two-bit saturating counter step.
    function automatic t_ctr2 train2(input t_ctr2 ctr, input logic up);
        t_ctr2 res;
        res = ctr;
        if (up) begin
            if (ctr != CTR_MAX) res = ctr + 2'd1;
        end else begin
            if (ctr != CTR_MIN) res = ctr - 2'd1;
        end
        return res;
    endfunction

endpackage

// File: rtl/core/tournament_branch_predictor.sv
// Top level of the tournament branch predictor (bimodal, gshare and chooser tables).
//
//  Channel  | Direction | Transaction carries
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | tdata: branch_pc[31:0], taken[32], zero pad to 40
//  m_axis   | out       | tdata: predicted_taken, used_gshare, prediction_correct,
//           |           |        correct_total[34:3], branch_total[66:35], pad to 72
//
// Each branch is handled by reading both table memories, then updating the entry
// and writing it back, so the read-modify-write of the memories sets the rate.
// After reset a clearing pass writes every table entry, during which no branch is
// accepted. A stalled result stays in the output register; the next branch may be
// accepted and looked up meanwhile, and waits only at its write-back.
module tournament_branch_predictor #(
    parameter int INDEX_BITS  = 11,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // Fields from bit 0: branch_pc (32), taken (1), zero pad.
    input  logic [tbp_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // Fields from bit 0: predicted_taken, used_gshare, prediction_correct,
    // correct_total (32), branch_total (32), zero pad.
    output logic [tbp_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);
    import tbp_pkg::*;

    localparam int DEPTH = 1 << INDEX_BITS;

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_LOOKUP = 2'd2;

    // Chooser in the upper half, bimodal in the lower half of each word.
    logic [3:0] r_mem_bc [0:DEPTH-1];
    t_ctr2      r_mem_g  [0:DEPTH-1];
    logic [3:0] r_rd_bc;
    t_ctr2      r_rd_g;

    logic [1:0]             r_state, n_state;
    logic [INDEX_BITS-1:0]  r_clr_idx;
    logic [INDEX_BITS-1:0]  r_hist;
    logic [INDEX_BITS-1:0]  r_idx;
    logic [INDEX_BITS-1:0]  r_gidx;
    logic                   r_taken;
    logic [COUNT_WIDTH-1:0] r_correct, n_correct;
    logic [COUNT_WIDTH-1:0] r_branch, n_branch;
    logic                   r_m_tvalid;
    logic [M_TDATA_W-1:0]   r_m_tdata;

    logic                  s_accept;
    logic                  do_update;
    logic [INDEX_BITS-1:0] in_idx;
    t_ctr2                 bctr, cctr, gctr;
    logic                  bpred, gpred, bok, gok, use_g, pred, ok;
    t_ctr2                 n_cctr, n_bctr, n_gctr;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign do_update       = (r_state == ST_LOOKUP) && (!r_m_tvalid || i_m_axis_tready);
    assign in_idx          = i_s_axis_tdata[S_PC_LSB +: INDEX_BITS];

    assign bctr  = r_rd_bc[1:0];
    assign cctr  = r_rd_bc[3:2];
    assign gctr  = r_rd_g;
    assign bpred = (bctr >= TAKEN_THRESH);
    assign gpred = (gctr >= TAKEN_THRESH);
    assign bok   = (bpred == r_taken);
    assign gok   = (gpred == r_taken);
    assign use_g = (cctr <= CHS_GSHARE_MAX);
    assign pred  = use_g ? gpred : bpred;
    assign ok    = use_g ? gok : bok;

    always_comb begin
        priority if (gok && !bok) begin
            n_cctr = train2(cctr, 1'b0);
        end else if (bok && !gok) begin
            n_cctr = train2(cctr, 1'b1);
        end else begin
            n_cctr = cctr;
        end
        n_bctr = train2(bctr, r_taken);
        n_gctr = train2(gctr, r_taken);
        n_branch  = (r_branch == '1) ? r_branch : r_branch + 1'b1;
        n_correct = (ok && (r_correct != '1)) ? r_correct + 1'b1 : r_correct;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (r_clr_idx == '1) n_state = ST_IDLE;
            ST_IDLE:   if (s_accept) n_state = ST_LOOKUP;
            ST_LOOKUP: if (do_update) n_state = ST_IDLE;
            default:   n_state = ST_CLEAR;
        endcase
    end

    // Table memories: one write port (clear or update), one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            r_mem_bc[r_clr_idx] <= {CHS_RESET, BIM_RESET};
        end else if (do_update) begin
            r_mem_bc[r_idx] <= {n_cctr, n_bctr};
        end
        if (s_accept) begin
            r_rd_bc <= r_mem_bc[in_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            r_mem_g[r_clr_idx] <= GSH_RESET;
        end else if (do_update) begin
            r_mem_g[r_gidx] <= n_gctr;
        end
        if (s_accept) begin
            r_rd_g <= r_mem_g[in_idx ^ r_hist];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_idx  <= '0;
            r_hist     <= '0;
            r_correct  <= '0;
            r_branch   <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (do_update) begin
                r_hist     <= {r_hist[INDEX_BITS-2:0], r_taken};
                r_correct  <= n_correct;
                r_branch   <= n_branch;
                r_m_tvalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_idx   <= in_idx;
            r_gidx  <= in_idx ^ r_hist;
            r_taken <= i_s_axis_tdata[S_TAKEN_BIT];
        end
        if (do_update) begin
            r_m_tdata <= M_TDATA_W'({TOTAL_W'(n_branch), TOTAL_W'(n_correct), ok, use_g, pred});
        end
    end

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;

endmodule

// File: rtl/core/tbp_checker.sv
// Port-level checker for the tournament branch predictor, bound to the top level.
module tbp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_axis_tvalid,
    input logic                          o_s_axis_tready,
    input logic [tbp_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [tbp_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);
    import tbp_pkg::*;

    logic s_xact;
    assign s_xact = i_s_axis_tvalid && o_s_axis_tready;

    // Reset empties the output and starts the clearing pass, so nothing is taken.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && !o_s_axis_tready)
        else $error("output valid or input ready right after reset");

    // A result that is not taken holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed or dropped");

    // A branch is in its lookup/update state right after it is taken in.
    a_busy_after_xact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_xact |=> !o_s_axis_tready)
        else $error("input ready during table update");

    // An empty output turns valid only after an input transaction and lookup.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(s_xact, 2))
        else $error("result without a preceding input transaction");

    // The unused high bits of the result stay zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[M_TDATA_W-1:M_USED_W] == '0)
        else $error("result padding not zero");

endmodule

bind tournament_branch_predictor tbp_checker u_tbp_checker (.*);
